FILE: hdl/sstf_pkg.sv
// Shared types and constants for the SSTF disk request scheduler.
// Used by sstf_front, sstf_back and sstf_disk_request_scheduler_core; no dependencies.
`default_nettype none
package sstf_pkg;

	// Default slot table depth and configuration reset values.
	localparam int DEF_SLOTS = 16;
	localparam logic [15:0] SERVICE_TIME_RST = 16'd100;
	localparam logic [16:0] NUM_CYLINDERS_RST = 17'd100;

	// Configuration register indexes and write data width.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TIME = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CYLINDERS = 1'd1;

	// Depth of the command queue between front and back.
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW = 1;
	localparam int FQ_CW = 2;

	// Command codes of the input word.
	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_SERVED = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_FULL = 3'd2,
		ST_RANGE = 3'd3,
		ST_NONE = 3'd4
	} status_t;

	// Classification made by the front before a command is queued.
	typedef enum logic [1:0] {
		K_SUBMIT = 2'd0,
		K_RANGE = 2'd1,
		K_DISPATCH = 2'd2
	} kind_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] req_id;
		logic [15:0] cylinder;
		logic [31:0] arrival_time;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] served_id;
		logic [15:0] served_cylinder;
		logic [15:0] seek_distance;
		logic [31:0] wait_time;
		logic [31:0] turnaround;
		logic [31:0] total_distance;
		logic [31:0] clock_now;
	} out_word_t;

	// One stored request: what a slot of the table holds.
	typedef struct packed {
		logic [7:0] id;
		logic [15:0] cyl;
		logic [31:0] arr;
	} slot_t;

	typedef struct packed {
		kind_t kind;
		slot_t req;
	} fq_entry_t;

endpackage
`default_nettype wire

FILE: hdl/sstf_front.sv
// Front end of the SSTF scheduler: classifies input words and queues them.
// Depends on sstf_pkg.
`default_nettype none
module sstf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [16:0] num_cylinders,
	input wire logic push,
	output logic full,
	input wire sstf_pkg::in_word_t req,
	output logic fq_empty,
	input wire logic fq_pop,
	output sstf_pkg::fq_entry_t fq_head
);
	import sstf_pkg::*;

	fq_entry_t entry_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wptr_q;
	logic [FQ_AW-1:0] rptr_q;
	logic [FQ_CW-1:0] count_q;
	fq_entry_t classified;
	logic do_push;
	logic do_pop;

	// The range check is made here so that the back only sees valid submits.
	always_comb begin
		classified.req.id = req.req_id;
		classified.req.cyl = req.cylinder;
		classified.req.arr = req.arrival_time;
		if (req.cmd == CMD_DISPATCH) begin
			classified.kind = K_DISPATCH;
		end else if ({1'b0, req.cylinder} >= num_cylinders) begin
			classified.kind = K_RANGE;
		end else begin
			classified.kind = K_SUBMIT;
		end
	end

	assign full = (count_q == FQ_CW'(FQ_DEPTH));
	assign fq_empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = fq_pop && !fq_empty;
	assign fq_head = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= classified;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sstf_back.sv
// Back end of the SSTF scheduler: slot table, scan, timing arithmetic and result register.
// Depends on sstf_pkg.
`default_nettype none
module sstf_back #(
	parameter int SLOTS = sstf_pkg::DEF_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [15:0] service_time,
	input wire logic fq_empty,
	output logic fq_pop,
	input wire sstf_pkg::fq_entry_t fq_head,
	output logic empty,
	input wire logic pop,
	output sstf_pkg::out_word_t rsp
);
	import sstf_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FREE  = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_FIN1  = 8'b0001_0000,
		S_FIN2  = 8'b0010_0000,
		S_FIN3  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [IW-1:0] slot;
		slot_t ent;
		logic [15:0] d;
	} cand_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] floor_sub32(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? (a - b) : 32'd0;
	endfunction

	state_t state_q;
	logic [IW-1:0] cnt_q;
	logic [SLOTS-1:0] valid_q;
	slot_t mem [SLOTS];
	slot_t rdata_s1;
	logic rvld_s1;
	logic [IW-1:0] ridx_s1;
	cand_t a_q;
	cand_t e_q;
	logic have_arr_q;
	logic have_any_q;
	cand_t pick_q;
	slot_t cmd_q;
	status_t status_q;
	logic [31:0] wait_q;
	logic [31:0] tat_q;
	logic [15:0] head_q;
	logic [31:0] clock_q;
	logic [31:0] dist_q;
	out_word_t res_q;
	logic res_valid_q;

	logic [15:0] d_s1;
	logic arrived_s1;
	cand_t cand_s1;
	logic a_upd;
	logic e_upd;
	cand_t sel;
	logic [31:0] clk_eff;
	logic mem_we;
	logic emit_fire;
	logic served;
	out_word_t res_d;

	// Candidate evaluation for the slot read out in the previous cycle.
	always_comb begin
		d_s1 = (rdata_s1.cyl >= head_q) ? (rdata_s1.cyl - head_q) : (head_q - rdata_s1.cyl);
		arrived_s1 = (rdata_s1.arr <= clock_q);
		cand_s1.slot = ridx_s1;
		cand_s1.ent = rdata_s1;
		cand_s1.d = d_s1;
		// Nearest arrived request, earlier arrival wins a tie, lower slot after that.
		a_upd = rvld_s1 && arrived_s1 && (!have_arr_q || (d_s1 < a_q.d) ||
			((d_s1 == a_q.d) && (rdata_s1.arr < a_q.ent.arr)));
		// Earliest pending request, nearer wins a tie; used when nothing has arrived.
		e_upd = rvld_s1 && (!have_any_q || (rdata_s1.arr < e_q.ent.arr) ||
			((rdata_s1.arr == e_q.ent.arr) && (d_s1 < e_q.d)));
	end

	assign sel = have_arr_q ? a_q : e_q;
	assign clk_eff = have_arr_q ? clock_q : e_q.ent.arr;
	assign fq_pop = (state_q == S_IDLE) && !fq_empty;
	assign mem_we = (state_q == S_FREE) && !valid_q[cnt_q];
	assign emit_fire = (state_q == S_EMIT) && (!res_valid_q || pop);
	assign served = (status_q == ST_SERVED);
	assign empty = !res_valid_q;
	assign rsp = res_q;

	always_comb begin
		res_d.status = status_q;
		res_d.served_id = served ? pick_q.ent.id : 8'd0;
		res_d.served_cylinder = served ? pick_q.ent.cyl : 16'd0;
		res_d.seek_distance = served ? pick_q.d : 16'd0;
		res_d.wait_time = served ? wait_q : 32'd0;
		res_d.turnaround = served ? tat_q : 32'd0;
		res_d.total_distance = dist_q;
		res_d.clock_now = clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			valid_q <= '0;
			rvld_s1 <= 1'b0;
			have_arr_q <= 1'b0;
			have_any_q <= 1'b0;
			status_q <= ST_NONE;
			head_q <= '0;
			clock_q <= '0;
			dist_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == S_SCAN) && valid_q[cnt_q];
			if (a_upd) begin
				have_arr_q <= 1'b1;
			end
			if (e_upd) begin
				have_any_q <= 1'b1;
			end
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!fq_empty) begin
						cnt_q <= '0;
						case (fq_head.kind)
							K_SUBMIT: state_q <= S_FREE;
							K_RANGE: begin
								status_q <= ST_RANGE;
								state_q <= S_EMIT;
							end
							K_DISPATCH: begin
								have_arr_q <= 1'b0;
								have_any_q <= 1'b0;
								state_q <= S_SCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FREE: begin
					if (!valid_q[cnt_q]) begin
						valid_q[cnt_q] <= 1'b1;
						status_q <= ST_ACCEPTED;
						state_q <= S_EMIT;
					end else if (cnt_q == LAST) begin
						status_q <= ST_FULL;
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_FIN1;
				S_FIN1: begin
					if (!have_any_q) begin
						status_q <= ST_NONE;
						state_q <= S_EMIT;
					end else begin
						clock_q <= sat_add32(clk_eff, {16'd0, sel.d});
						dist_q <= sat_add32(dist_q, {16'd0, sel.d});
						state_q <= S_FIN2;
					end
				end
				S_FIN2: begin
					clock_q <= sat_add32(clock_q, {16'd0, service_time});
					state_q <= S_FIN3;
				end
				S_FIN3: begin
					head_q <= pick_q.ent.cyl;
					valid_q[pick_q.slot] <= 1'b0;
					status_q <= ST_SERVED;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q;
		if (a_upd) begin
			a_q <= cand_s1;
		end
		if (e_upd) begin
			e_q <= cand_s1;
		end
		if (fq_pop) begin
			cmd_q <= fq_head.req;
		end
		if (state_q == S_FIN1) begin
			pick_q <= sel;
		end
		if (state_q == S_FIN2) begin
			wait_q <= floor_sub32(clock_q, pick_q.ent.arr);
		end
		if (state_q == S_FIN3) begin
			tat_q <= floor_sub32(clock_q, pick_q.ent.arr);
		end
		if (emit_fire) begin
			res_q <= res_d;
		end
	end

	// Slot table: one write port for submits, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q] <= cmd_q;
		end
		rdata_s1 <= mem[cnt_q];
	end

endmodule
`default_nettype wire

FILE: hdl/sstf_disk_request_scheduler_core.sv
// Top level of the SSTF disk request scheduler: configuration registers,
// front classifier with command queue (sstf_front) and executing back end (sstf_back).
`default_nettype none
// Channel    Handshake        Word          Direction
// request    push / full      req           in
// result     empty / pop      rsp           out
// config     cfg_wen          cfg_index,    in
//                             cfg_data
//
// A submit word searches the slots in order for the lowest free one; an
// out-of-range submit goes straight to the result. A dispatch word scans every
// slot: the slot table has one read port, so the scan reads one slot per cycle,
// then the timing arithmetic runs in S_FIN1, S_FIN2 and S_FIN3 (only S_FIN1
// when nothing is pending).
// The command queue holds two words, so the front keeps taking words while
// the back works or while a finished result waits to be popped.
// Reset is asynchronous and needs no clearing pass; of the slot table only the valid bits clear.
module sstf_disk_request_scheduler_core #(
	parameter int SLOTS = sstf_pkg::DEF_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire sstf_pkg::in_word_t req,
	output logic empty,
	input wire logic pop,
	output sstf_pkg::out_word_t rsp,
	input wire logic cfg_wen,
	input wire logic [sstf_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sstf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sstf_pkg::*;

	logic [15:0] service_time_q;
	logic [16:0] num_cylinders_q;
	logic fq_empty;
	logic fq_pop;
	fq_entry_t fq_head;

	// The user must write configuration only while the block is idle (the block
	// does not enforce this), so both halves may read the registers directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_time_q <= SERVICE_TIME_RST;
			num_cylinders_q <= NUM_CYLINDERS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SERVICE_TIME: service_time_q <= cfg_data[15:0];
				CFG_NUM_CYLINDERS: num_cylinders_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// The front tags each word as submit, out-of-range submit or dispatch.
	sstf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.num_cylinders(num_cylinders_q),
		.push(push),
		.full(full),
		.req(req),
		.fq_empty(fq_empty),
		.fq_pop(fq_pop),
		.fq_head(fq_head)
	);

	// The back owns the slot table, head, clock and distance sum, and holds
	// the result register that the result channel reads.
	sstf_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.service_time(service_time_q),
		.fq_empty(fq_empty),
		.fq_pop(fq_pop),
		.fq_head(fq_head),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

FILE: tb/sstf_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the SSTF disk request scheduler. It keeps its own slot table, head,
// clock and distance sum, predicts every result word and compares it. Needs sstf_pkg.
module sstf_result_checker #(
	parameter int SLOTS = sstf_pkg::DEF_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input sstf_pkg::in_word_t req,
	input wire logic empty,
	input wire logic pop,
	input sstf_pkg::out_word_t rsp,
	input wire logic cfg_wen,
	input wire logic [sstf_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sstf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int outstanding,
	output logic [31:0] sched_clock
);
	import sstf_pkg::*;

	logic slot_busy [SLOTS];
	logic [7:0] slot_ident [SLOTS];
	logic [15:0] slot_cyl [SLOTS];
	logic [31:0] slot_arr [SLOTS];
	logic [15:0] head_cyl;
	logic [31:0] sched_time;
	logic [31:0] seek_total;
	logic [15:0] svc_time;
	logic [16:0] cyl_limit;
	out_word_t expected_words [$];

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : 32'd0;
	endfunction

	// Applies one word to the mirrored table and returns the result it must produce.
	task automatic predict_word(input in_word_t w, output out_word_t r);
		int free_slot;
		int best;
		logic any_pending;
		logic any_arrived;
		logic [31:0] earliest;
		logic [15:0] seek_len;
		logic [15:0] best_dist;
		r = '0;
		if (w.cmd == CMD_SUBMIT) begin
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_busy[i])
					free_slot = i;
			// The range check wins over a full table.
			if ({1'b0, w.cylinder} >= cyl_limit) begin
				r.status = ST_RANGE;
			end else if (free_slot < 0) begin
				r.status = ST_FULL;
			end else begin
				slot_busy[free_slot] = 1'b1;
				slot_ident[free_slot] = w.req_id;
				slot_cyl[free_slot] = w.cylinder;
				slot_arr[free_slot] = w.arrival_time;
				r.status = ST_ACCEPTED;
			end
		end else begin
			any_pending = 1'b0;
			any_arrived = 1'b0;
			earliest = '0;
			best = -1;
			best_dist = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_busy[i]) begin
					if (!any_pending || slot_arr[i] < earliest)
						earliest = slot_arr[i];
					any_pending = 1'b1;
					if (slot_arr[i] <= sched_time)
						any_arrived = 1'b1;
				end
			end
			if (!any_pending) begin
				r.status = ST_NONE;
			end else begin
				// Idle disk: time skips ahead to the first request that shows up.
				if (!any_arrived)
					sched_time = earliest;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_busy[i] && slot_arr[i] <= sched_time) begin
						seek_len = (slot_cyl[i] >= head_cyl) ? slot_cyl[i] - head_cyl
							: head_cyl - slot_cyl[i];
						if (best < 0 || seek_len < best_dist
								|| (seek_len == best_dist && slot_arr[i] < slot_arr[best])) begin
							best = i;
							best_dist = seek_len;
						end
					end
				end
				seek_total = add_sat(seek_total, {16'd0, best_dist});
				sched_time = add_sat(sched_time, {16'd0, best_dist});
				r.wait_time = sub_floor(sched_time, slot_arr[best]);
				sched_time = add_sat(sched_time, {16'd0, svc_time});
				r.turnaround = sub_floor(sched_time, slot_arr[best]);
				r.status = ST_SERVED;
				r.served_id = slot_ident[best];
				r.served_cylinder = slot_cyl[best];
				r.seek_distance = best_dist;
				head_cyl = slot_cyl[best];
				slot_busy[best] = 1'b0;
			end
		end
		r.total_distance = seek_total;
		r.clock_now = sched_time;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_busy[i] = 1'b0;
			head_cyl = '0;
			sched_time = '0;
			seek_total = '0;
			svc_time = SERVICE_TIME_RST;
			cyl_limit = NUM_CYLINDERS_RST;
			expected_words.delete();
			errors = 0;
			outstanding = 0;
			sched_clock = '0;
		end else begin
			// A word popped now belongs to an older item, so compare before predicting.
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected: expected nothing, actual %h",
						$time, rsp);
				end else begin
					want = expected_words.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("served_id", 32'(want.served_id), 32'(rsp.served_id));
					check_field("served_cylinder", 32'(want.served_cylinder),
						32'(rsp.served_cylinder));
					check_field("seek_distance", 32'(want.seek_distance),
						32'(rsp.seek_distance));
					check_field("wait_time", want.wait_time, rsp.wait_time);
					check_field("turnaround", want.turnaround, rsp.turnaround);
					check_field("total_distance", want.total_distance, rsp.total_distance);
					check_field("clock_now", want.clock_now, rsp.clock_now);
				end
			end
			if (cfg_wen) begin
				if (cfg_index == CFG_SERVICE_TIME)
					svc_time = cfg_data[15:0];
				else if (cfg_index == CFG_NUM_CYLINDERS)
					cyl_limit = cfg_data;
			end
			if (push && !full) begin
				predict_word(req, want);
				expected_words.insert(expected_words.size(), want);
			end
			outstanding = expected_words.size();
			sched_clock = sched_time;
		end
	end

endmodule

FILE: tb/tb_sstf_disk_request_scheduler_core.sv
`timescale 1ns / 100ps
// Top of the SSTF scheduler testbench: clock, reset, request and config stimulus,
// result popping and the verdict. Needs sstf_pkg, the core and sstf_result_checker.
module tb_sstf_disk_request_scheduler_core;
	import sstf_pkg::*;

	localparam int SLOTS = DEF_SLOTS;
	// Margin after the last result, enough to cover a dispatch in flight and then some.
	localparam int DRAIN_CYCLES = SLOTS + 12;
	localparam int PHASE_ITEMS = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_word_t req = '0;
	logic empty;
	logic pop = 1'b0;
	out_word_t rsp;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int outstanding;
	logic [31:0] sched_clock;

	// Knobs of the current phase. Percentages are chances out of a hundred at each draw.
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int submit_pct = 50;
	// Mirror of the cylinder limit last written, used to aim submits in range.
	logic [16:0] cyl_limit = NUM_CYLINDERS_RST;

	sstf_disk_request_scheduler_core #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sstf_result_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding),
		.sched_clock(sched_clock)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The result side decides once per cycle whether it takes a word. Driving pop on the
	// falling edge keeps it stable around the rising edge where the handshake happens.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// Hard stop in case the block hangs or a result never shows up.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic in_word_t submit_word(input logic [7:0] id, input logic [15:0] cyl,
			input logic [31:0] arr);
		in_word_t w;
		w.cmd = CMD_SUBMIT;
		w.req_id = id;
		w.cylinder = cyl;
		w.arrival_time = arr;
		return w;
	endfunction

	// The other fields mean nothing to a dispatch, so they carry random bits.
	function automatic in_word_t dispatch_word();
		in_word_t w;
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		w = noise[$bits(in_word_t)-1:0];
		w.cmd = CMD_DISPATCH;
		return w;
	endfunction

	// Offers one word on the request side. Called and returning on a falling edge.
	// While the sender idles the request bus carries junk to show that push alone counts.
	// push is only raised or lowered once per edge, so back-to-back words keep it high.
	task automatic send_word(input in_word_t w);
		logic [63:0] junk;
		while ($urandom_range(99) < send_idle_pct) begin
			junk = {$urandom, $urandom};
			push <= 1'b0;
			req <= junk[$bits(in_word_t)-1:0];
			@(negedge clk);
		end
		push <= 1'b1;
		req <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register writes take effect at the next rising edge; the extra falling edge keeps
	// consecutive writes from touching cfg_wen twice in one time step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
		if (idx == CFG_NUM_CYLINDERS)
			cyl_limit = val;
	endtask

	// Stops sending and waits until every word sent has come back, then a little longer.
	// Registers are only written after this, with the block idle.
	task automatic settle();
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// One random item. Most are well-formed submits and dispatches with arrivals placed
	// around the scheduler's current time, so requests are a mix of already arrived and
	// still to come. A few are out-of-range submits with fully random fields: the block
	// rejects them, so their wild arrival times never drag the clock forward.
	task automatic send_random_word();
		logic [31:0] arr;
		logic [31:0] span;
		logic [15:0] cyl;
		int roll;
		roll = $urandom_range(99);
		if (roll < 6 && cyl_limit <= 17'd65535) begin
			cyl = 16'($urandom_range(65535, int'(cyl_limit)));
			send_word(submit_word(8'($urandom), cyl, $urandom));
		end else if (roll < 6 + submit_pct) begin
			if (cyl_limit == 0)
				cyl = 16'($urandom);
			else if ($urandom_range(1) == 0)
				cyl = 16'($urandom_range(int'(cyl_limit) - 1));
			else
				// A small cluster near the bottom makes equal seek distances common.
				cyl = 16'($urandom_range((cyl_limit > 32) ? 31 : int'(cyl_limit) - 1));
			span = $urandom_range(4000);
			if ($urandom_range(7) == 0)
				arr = sched_clock;
			else if ($urandom_range(3) == 0)
				arr = sched_clock + span + 32'd1;
			else
				arr = (sched_clock > span) ? sched_clock - span : 32'd0;
			send_word(submit_word(8'($urandom), cyl, arr));
		end else begin
			send_word(dispatch_word());
		end
	endtask

	initial begin
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at the reset settings (service time 100, 100 cylinders).
		// Dispatch with an empty table, then the top in-range cylinder and the first
		// out-of-range one.
		send_word(dispatch_word());
		send_word(submit_word(8'hFF, 16'd99, 32'd0));
		send_word(submit_word(8'h00, 16'd100, 32'd0));
		// Fill the rest of the table. Slots 2 to 4 share cylinder and arrival, so the
		// lowest slot must win; slot 1 sits on the same cylinder but arrives later.
		for (int k = 1; k < SLOTS; k++)
			send_word(submit_word(8'(k), (k < 5) ? 16'd10 : 16'(k * 6),
				(k == 1) ? 32'd50 : ((k < 5) ? 32'd20 : 32'(k * 9))));
		// A full table rejects a good submit; an out-of-range one still reports range.
		send_word(submit_word(8'h5A, 16'd5, 32'd0));
		send_word(submit_word(8'hA5, 16'hFFFF, 32'hFFFF_FFFF));
		repeat (3)
			send_word(dispatch_word());
		settle();

		// Random part in four phases, each with its own idling pattern and settings.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					pop_stall_pct = 0;
					write_reg(CFG_SERVICE_TIME, 17'd0);
					write_reg(CFG_NUM_CYLINDERS, 17'h10000);
				end
				1: begin
					send_idle_pct = 74;
					pop_stall_pct = 0;
					write_reg(CFG_SERVICE_TIME, 17'd37);
					write_reg(CFG_NUM_CYLINDERS, 17'd1);
				end
				2: begin
					send_idle_pct = 0;
					pop_stall_pct = 74;
					write_reg(CFG_SERVICE_TIME, 17'h0FFFF);
					write_reg(CFG_NUM_CYLINDERS, 17'd300);
				end
				default: begin
					send_idle_pct = 15;
					pop_stall_pct = 15;
					write_reg(CFG_SERVICE_TIME, 17'($urandom_range(500)));
					write_reg(CFG_NUM_CYLINDERS, NUM_CYLINDERS_RST);
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Shift the submit/dispatch balance now and then so the table both
				// fills up and runs dry.
				if (n % 40 == 0)
					submit_pct = $urandom_range(64, 30);
				send_random_word();
			end
			settle();
		end

		// With a zero cylinder limit every submit is out of range.
		send_idle_pct = 15;
		pop_stall_pct = 15;
		write_reg(CFG_NUM_CYLINDERS, 17'd0);
		send_word(submit_word(8'h11, 16'd0, 32'd0));
		repeat (10)
			send_word(submit_word(8'($urandom), 16'($urandom), $urandom));
		settle();

		// Saturation at the end, since a clock pinned at its maximum stays there.
		// First empty the table, then park two requests far in the future: the first
		// dispatch jumps the clock to them and the seek plus the long service overflows it.
		write_reg(CFG_SERVICE_TIME, 17'h0FFFF);
		write_reg(CFG_NUM_CYLINDERS, 17'h10000);
		repeat (SLOTS)
			send_word(dispatch_word());
		send_word(submit_word(8'hAA, 16'hFFFF, 32'hFFFF_FFFF));
		send_word(submit_word(8'h55, 16'h0000, 32'hFFFF_FF00));
		repeat (2)
			send_word(dispatch_word());
		send_word(submit_word(8'h3C, 16'd12345, 32'd0));
		repeat (2)
			send_word(dispatch_word());
		settle();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
